// ===== sv/cvr_pkg.sv =====
`default_nettype none

package cvr_pkg;

    localparam int NORM_FRAC = 14;
    localparam int COEF_FRAC = 12;
    localparam int MUL_FRAC  = 16;
    localparam int WGT_FRAC  = 24;

    localparam int PROD_W = 48;   // 32 x 16 signed product
    localparam int DOT_W  = 49;   // sum of two products
    localparam int VN_W   = DOT_W - NORM_FRAC;
    localparam int CO_W   = 41;   // tangent/normal coefficient after the response
    localparam int SAT_W  = CO_W + 16 + 1 - NORM_FRAC;

    localparam int DIV_W     = 62;
    localparam int DIV_STEPS = WGT_FRAC;

    localparam logic [12:0] COEF_ONE = 13'd4096;
    localparam logic [16:0] M_ONE    = 17'h10000;
    localparam logic [24:0] WGT_ONE  = 25'h1000000;
    localparam logic [24:0] WGT_HALF = 25'h0800000;

    typedef enum logic [1:0] {
        OUT_PASS = 2'd0,
        OUT_WALL = 2'd1,
        OUT_PAIR = 2'd2
    } outcome_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [31:0] own_vel_x;
        logic signed [31:0] own_vel_y;
        logic        [31:0] own_mass;
        logic               partner_present;
        logic signed [31:0] other_vel_x;
        logic signed [31:0] other_vel_y;
        logic        [31:0] other_mass;
        logic        [15:0] friction_coef;
        logic        [12:0] bounce_coef;
    } cvr_in_t;

    typedef struct packed {
        logic signed [31:0] new_own_vel_x;
        logic signed [31:0] new_own_vel_y;
        logic signed [31:0] new_other_vel_x;
        logic signed [31:0] new_other_vel_y;
        logic        [1:0]  outcome;
    } cvr_out_t;

    // contact context carried alongside the divider
    typedef struct packed {
        outcome_t                mode;
        logic                    m_zero;
        logic                    total_zero;
        logic signed [VN_W-1:0]  vna;
        logic signed [VN_W-1:0]  vta;
        logic signed [VN_W-1:0]  vnb;
        logic signed [VN_W-1:0]  vtb;
        logic        [12:0]      e;
        logic signed [15:0]      nx;
        logic signed [15:0]      ny;
        logic signed [31:0]      vax;
        logic signed [31:0]      vay;
        logic signed [31:0]      vbx;
        logic signed [31:0]      vby;
    } cvr_ctx_t;

    typedef struct packed {
        logic [DIV_W-1:0]     rem;
        logic [DIV_W-1:0]     den;
        logic [DIV_STEPS-1:0] q;
        logic                 full;
    } cvr_div_t;

    // one restoring division step
    function automatic cvr_div_t div_step(input cvr_div_t d);
        logic [DIV_W-1:0] r2;
        cvr_div_t         r;
        r2 = {d.rem[DIV_W-2:0], 1'b0};
        r  = d;
        if (r2 >= d.den)
        begin
            r.rem = r2 - d.den;
            r.q   = {d.q[DIV_STEPS-2:0], 1'b1};
        end
        else
        begin
            r.rem = r2;
            r.q   = {d.q[DIV_STEPS-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
        logic signed [31:0] r;
        if ((&x[SAT_W-1:31]) || (~|x[SAT_W-1:31]))
            r = x[31:0];
        else if (x[SAT_W-1])
            r = 32'sh80000000;
        else
            r = 32'sh7fffffff;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/cvr_in_if.sv =====
`default_nettype none

interface cvr_in_if;
    logic             valid;
    logic             ready;
    cvr_pkg::cvr_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/cvr_out_if.sv =====
`default_nettype none

interface cvr_out_if;
    logic              valid;
    logic              ready;
    cvr_pkg::cvr_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/contact_velocity_response_2d.sv =====
// An accepted request passes 4 front stages, 24 restoring-divider stages,
//   5 back stages and the output register.
// Throughput: one request per cycle while the skid is empty; the divider sets depth.
// Reset: rst_n clears all valid bits and the output/skid flags asynchronously;
//   data registers are not reset.
`default_nettype none

module contact_velocity_response_2d (
    input  wire logic clk,
    input  wire logic rst_n,
    cvr_in_if.sink    contact,
    cvr_out_if.source result
);

    // The whole pipeline advances together. A request in the last stage moves
    // into the output register, or into the skid register when the output is
    // still held. A full skid stalls the pipe, so ready is a register output.
    logic en;

    logic              f_vld, d_vld, b_vld;
    cvr_pkg::cvr_ctx_t f_ctx, d_ctx;
    cvr_pkg::cvr_div_t f_div, d_div;
    cvr_pkg::cvr_out_t b_data;

    logic              out_vld_reg, out_vld_next;
    logic              skid_vld_reg, skid_vld_next;
    cvr_pkg::cvr_out_t out_reg, out_next;
    cvr_pkg::cvr_out_t skid_reg, skid_next;
    logic              take, push;

    assign en            = !skid_vld_reg;
    assign contact.ready = en;

    cvr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (contact.valid),
        .in_data (contact.data),
        .out_vld (f_vld),
        .out_ctx (f_ctx),
        .out_div (f_div)
    );

    cvr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (f_vld),
        .in_div  (f_div),
        .in_ctx  (f_ctx),
        .out_vld (d_vld),
        .out_div (d_div),
        .out_ctx (d_ctx)
    );

    cvr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (d_vld),
        .in_div   (d_div),
        .in_ctx   (d_ctx),
        .out_vld  (b_vld),
        .out_data (b_data)
    );

    assign take = out_vld_reg && result.ready;
    assign push = b_vld && en;

    always_comb
    begin
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (take || !out_vld_reg)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_next     = b_data;
                out_vld_next = push;
            end
        end
        else if (push)
        begin
            skid_next     = b_data;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;

    // skid only holds a request behind an occupied output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register holds a request with an empty output");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !result.ready))
        else $error("skid filled while output was free");

    // a taken output with a full skid drains the skid
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_vld_reg && result.ready) |=> !skid_vld_reg)
        else $error("skid did not drain");

endmodule

`default_nettype wire

// ===== sv/cvr_front.sv =====
`default_nettype none

// Dot products, approach test and divider operand setup: four stages.
module cvr_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire cvr_pkg::cvr_in_t  in_data,
    output logic                   out_vld,
    output cvr_pkg::cvr_ctx_t      out_ctx,
    output cvr_pkg::cvr_div_t      out_div
);

    typedef struct packed {
        logic signed [cvr_pkg::PROD_W-1:0] axn;
        logic signed [cvr_pkg::PROD_W-1:0] ayn;
        logic signed [cvr_pkg::PROD_W-1:0] axt;
        logic signed [cvr_pkg::PROD_W-1:0] ayt;
        logic signed [cvr_pkg::PROD_W-1:0] bxn;
        logic signed [cvr_pkg::PROD_W-1:0] byn;
        logic signed [cvr_pkg::PROD_W-1:0] bxt;
        logic signed [cvr_pkg::PROD_W-1:0] byt;
    } prod_t;

    typedef struct packed {
        logic signed [cvr_pkg::DOT_W-1:0] dna;
        logic signed [cvr_pkg::DOT_W-1:0] dta;
        logic signed [cvr_pkg::DOT_W-1:0] dnb;
        logic signed [cvr_pkg::DOT_W-1:0] dtb;
    } dot_t;

    typedef struct packed {
        logic [47:0] a;
        logic [63:0] fb;
    } wall_t;

    logic [3:0]        vld_reg;
    cvr_pkg::cvr_in_t  in1_reg, in2_reg, in3_reg;
    prod_t             p_reg, p_next;
    dot_t              d_reg, d_next;
    wall_t             w_reg, w_next;
    cvr_pkg::cvr_ctx_t c3_reg, c3_next, c4_reg, c4_next;
    cvr_pkg::cvr_div_t div_reg, div_next;

    // stage 1: products
    always_comb
    begin
        p_next.axn = $signed(in_data.own_vel_x) * $signed(in_data.normal_x);
        p_next.ayn = $signed(in_data.own_vel_y) * $signed(in_data.normal_y);
        p_next.axt = $signed(in_data.own_vel_x) * $signed(in_data.normal_y);
        p_next.ayt = $signed(in_data.own_vel_y) * $signed(in_data.normal_x);
        p_next.bxn = $signed(in_data.other_vel_x) * $signed(in_data.normal_x);
        p_next.byn = $signed(in_data.other_vel_y) * $signed(in_data.normal_y);
        p_next.bxt = $signed(in_data.other_vel_x) * $signed(in_data.normal_y);
        p_next.byt = $signed(in_data.other_vel_y) * $signed(in_data.normal_x);
    end

    // stage 2: dot products, tangent t = (ny, -nx)
    always_comb
    begin
        d_next.dna = $signed(p_reg.axn) + $signed(p_reg.ayn);
        d_next.dta = $signed(p_reg.axt) - $signed(p_reg.ayt);
        d_next.dnb = $signed(p_reg.bxn) + $signed(p_reg.byn);
        d_next.dtb = $signed(p_reg.bxt) - $signed(p_reg.byt);
    end

    // stage 3: approach test, scaled components, friction product
    logic signed [cvr_pkg::DOT_W:0]   dn_diff;
    logic signed [cvr_pkg::DOT_W-1:0] abs_t, neg_n;
    logic signed [cvr_pkg::DOT_W-1:0] sh_na, sh_ta, sh_nb, sh_tb;

    always_comb
    begin
        dn_diff = $signed(d_reg.dna) - $signed(d_reg.dnb);
        abs_t   = d_reg.dta[cvr_pkg::DOT_W-1] ? -d_reg.dta : d_reg.dta;
        neg_n   = -d_reg.dna;
        sh_na   = d_reg.dna >>> cvr_pkg::NORM_FRAC;
        sh_ta   = d_reg.dta >>> cvr_pkg::NORM_FRAC;
        sh_nb   = d_reg.dnb >>> cvr_pkg::NORM_FRAC;
        sh_tb   = d_reg.dtb >>> cvr_pkg::NORM_FRAC;

        w_next.a  = abs_t[47:0];
        w_next.fb = in2_reg.friction_coef * neg_n[47:0];

        c3_next            = '0;
        c3_next.vna        = sh_na[cvr_pkg::VN_W-1:0];
        c3_next.vta        = sh_ta[cvr_pkg::VN_W-1:0];
        c3_next.vnb        = sh_nb[cvr_pkg::VN_W-1:0];
        c3_next.vtb        = sh_tb[cvr_pkg::VN_W-1:0];
        c3_next.e          = in2_reg.bounce_coef;
        c3_next.nx         = in2_reg.normal_x;
        c3_next.ny         = in2_reg.normal_y;
        c3_next.vax        = in2_reg.own_vel_x;
        c3_next.vay        = in2_reg.own_vel_y;
        c3_next.vbx        = in2_reg.other_vel_x;
        c3_next.vby        = in2_reg.other_vel_y;
        if (in2_reg.partner_present)
            c3_next.mode = (!dn_diff[cvr_pkg::DOT_W] && (dn_diff != '0))
                           ? cvr_pkg::OUT_PAIR : cvr_pkg::OUT_PASS;
        else
            c3_next.mode = d_reg.dna[cvr_pkg::DOT_W-1] ? cvr_pkg::OUT_WALL
                                                       : cvr_pkg::OUT_PASS;
    end

    // stage 4: divider operands
    logic [cvr_pkg::DIV_W-1:0] den_w;
    logic [32:0]               total;

    always_comb
    begin
        den_w   = {2'b00, w_reg.a, 12'h000};
        total   = {1'b0, in3_reg.own_mass} + {1'b0, in3_reg.other_mass};
        c4_next = c3_reg;
        div_next      = '0;
        c4_next.m_zero     = (w_reg.a == '0) || (w_reg.fb >= {2'b00, den_w});
        c4_next.total_zero = (total == '0);
        if (in3_reg.partner_present)
        begin
            div_next.den = {{(cvr_pkg::DIV_W-33){1'b0}}, total};
            div_next.rem = {{(cvr_pkg::DIV_W-32){1'b0}}, in3_reg.other_mass};
        end
        else
        begin
            div_next.den = den_w;
            div_next.rem = den_w - w_reg.fb[cvr_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in1_reg <= in_data;
            p_reg   <= p_next;
            in2_reg <= in1_reg;
            d_reg   <= d_next;
            in3_reg <= in2_reg;
            w_reg   <= w_next;
            c3_reg  <= c3_next;
            c4_reg  <= c4_next;
            div_reg <= div_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[2:0], in_vld};
    end

    assign out_vld = vld_reg[3];
    assign out_ctx = c4_reg;
    assign out_div = div_reg;

endmodule

`default_nettype wire

// ===== sv/cvr_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per stage.
module cvr_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire cvr_pkg::cvr_div_t in_div,
    input  wire cvr_pkg::cvr_ctx_t in_ctx,
    output logic                   out_vld,
    output cvr_pkg::cvr_div_t      out_div,
    output cvr_pkg::cvr_ctx_t      out_ctx
);

    localparam int N = cvr_pkg::DIV_STEPS;

    cvr_pkg::cvr_div_t stg_reg [N];
    cvr_pkg::cvr_div_t src     [N];
    cvr_pkg::cvr_ctx_t ctx_reg [N];
    logic [N-1:0]      vld_reg;

    always_comb
    begin
        src[0]      = in_div;
        src[0].full = in_div.rem >= in_div.den;  // quotient saturates at one
        for (int k = 1; k < N; k++)
            src[k] = stg_reg[k-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < N; k++)
                stg_reg[k] <= cvr_pkg::div_step(src[k]);
            ctx_reg[0] <= in_ctx;
            for (int k = 1; k < N; k++)
                ctx_reg[k] <= ctx_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[N-2:0], in_vld};
    end

    assign out_vld = vld_reg[N-1];
    assign out_div = stg_reg[N-1];
    assign out_ctx = ctx_reg[N-1];

endmodule

`default_nettype wire

// ===== sv/cvr_back.sv =====
`default_nettype none

// Response math and recombination onto x/y: five stages.
module cvr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire cvr_pkg::cvr_div_t in_div,
    input  wire cvr_pkg::cvr_ctx_t in_ctx,
    output logic                   out_vld,
    output cvr_pkg::cvr_out_t      out_data
);

    localparam int CW = cvr_pkg::CO_W;
    localparam int PW = CW + 16;

    typedef struct packed {
        logic signed [52:0] pt;
        logic signed [48:0] pn;
        logic signed [50:0] pj;
        logic        [24:0] wa;
        logic        [24:0] wb;
    } b1_t;

    typedef struct packed {
        logic signed [CW-1:0] vt2;
        logic signed [CW-1:0] vn2;
        logic signed [64:0]   jwb;
        logic signed [64:0]   jwa;
    } b2_t;

    typedef struct packed {
        logic signed [CW-1:0] at;
        logic signed [CW-1:0] an;
        logic signed [CW-1:0] bt;
        logic signed [CW-1:0] bn;
    } b3_t;

    typedef struct packed {
        logic signed [PW-1:0] ax1;
        logic signed [PW-1:0] ax2;
        logic signed [PW-1:0] ay1;
        logic signed [PW-1:0] ay2;
        logic signed [PW-1:0] bx1;
        logic signed [PW-1:0] bx2;
        logic signed [PW-1:0] by1;
        logic signed [PW-1:0] by2;
    } b4_t;

    cvr_pkg::cvr_ctx_t ctx_reg [4];
    logic [4:0]        vld_reg;
    b1_t               b1_reg, b1_next;
    b2_t               b2_reg, b2_next;
    b3_t               b3_reg, b3_next;
    b4_t               b4_reg, b4_next;
    cvr_pkg::cvr_out_t o_reg, o_next;

    // stage 1: friction scale, weights, impulse product
    logic [16:0]               m_v;
    logic signed [cvr_pkg::VN_W:0] dvn;
    logic [14:0]               eplus;

    always_comb
    begin
        if (in_ctx.m_zero)
            m_v = '0;
        else if (in_div.full)
            m_v = cvr_pkg::M_ONE;
        else
            m_v = {1'b0, in_div.q[cvr_pkg::DIV_STEPS-1:cvr_pkg::WGT_FRAC-cvr_pkg::MUL_FRAC]};

        if (in_ctx.total_zero)
        begin
            b1_next.wb = cvr_pkg::WGT_HALF;
            b1_next.wa = cvr_pkg::WGT_HALF;
        end
        else if (in_div.full)
        begin
            b1_next.wb = cvr_pkg::WGT_ONE;
            b1_next.wa = '0;
        end
        else
        begin
            // floor(ma/M) = 1 - ceil(mb/M)
            b1_next.wb = {1'b0, in_div.q};
            b1_next.wa = cvr_pkg::WGT_ONE - {1'b0, in_div.q}
                         - {24'd0, (in_div.rem != '0)};
        end

        dvn   = $signed(in_ctx.vna) - $signed(in_ctx.vnb);
        eplus = {2'b00, in_ctx.e} + {2'b00, cvr_pkg::COEF_ONE};
        b1_next.pt = $signed(in_ctx.vta) * $signed({1'b0, m_v});
        b1_next.pn = $signed(in_ctx.vna) * $signed({1'b0, in_ctx.e});
        b1_next.pj = dvn * $signed({1'b0, eplus});
    end

    // stage 2: wall components, pair exchange products
    logic signed [52:0] sh_t;
    logic signed [48:0] sh_n;
    logic signed [50:0] sh_j;
    logic signed [38:0] j_v;

    always_comb
    begin
        sh_t        = b1_reg.pt >>> cvr_pkg::MUL_FRAC;
        sh_n        = -(b1_reg.pn >>> cvr_pkg::COEF_FRAC);
        sh_j        = b1_reg.pj >>> cvr_pkg::COEF_FRAC;
        j_v         = sh_j[38:0];
        b2_next.vt2 = sh_t[CW-1:0];
        b2_next.vn2 = sh_n[CW-1:0];
        b2_next.jwb = j_v * $signed({1'b0, b1_reg.wb});
        b2_next.jwa = j_v * $signed({1'b0, b1_reg.wa});
    end

    // stage 3: per-body tangent/normal coefficients
    logic signed [64:0] sh_b, sh_a;

    always_comb
    begin
        sh_b = b2_reg.jwb >>> cvr_pkg::WGT_FRAC;
        sh_a = b2_reg.jwa >>> cvr_pkg::WGT_FRAC;
        if (ctx_reg[1].mode == cvr_pkg::OUT_WALL)
        begin
            b3_next.at = b2_reg.vt2;
            b3_next.an = b2_reg.vn2;
        end
        else
        begin
            b3_next.at = CW'(ctx_reg[1].vta);
            b3_next.an = CW'(ctx_reg[1].vna) - sh_b[CW-1:0];
        end
        b3_next.bt = CW'(ctx_reg[1].vtb);
        b3_next.bn = CW'(ctx_reg[1].vnb) + sh_a[CW-1:0];
    end

    // stage 4: projection back onto x/y
    always_comb
    begin
        b4_next.ax1 = b3_reg.at * ctx_reg[2].ny;
        b4_next.ax2 = b3_reg.an * ctx_reg[2].nx;
        b4_next.ay1 = b3_reg.at * ctx_reg[2].nx;
        b4_next.ay2 = b3_reg.an * ctx_reg[2].ny;
        b4_next.bx1 = b3_reg.bt * ctx_reg[2].ny;
        b4_next.bx2 = b3_reg.bn * ctx_reg[2].nx;
        b4_next.by1 = b3_reg.bt * ctx_reg[2].nx;
        b4_next.by2 = b3_reg.bn * ctx_reg[2].ny;
    end

    // stage 5: sums, saturation, pass-through select
    logic signed [PW:0] s_ax, s_ay, s_bx, s_by;

    always_comb
    begin
        s_ax = ($signed(b4_reg.ax1) + $signed(b4_reg.ax2)) >>> cvr_pkg::NORM_FRAC;
        s_ay = ($signed(b4_reg.ay2) - $signed(b4_reg.ay1)) >>> cvr_pkg::NORM_FRAC;
        s_bx = ($signed(b4_reg.bx1) + $signed(b4_reg.bx2)) >>> cvr_pkg::NORM_FRAC;
        s_by = ($signed(b4_reg.by2) - $signed(b4_reg.by1)) >>> cvr_pkg::NORM_FRAC;
        o_next.outcome         = ctx_reg[3].mode;
        o_next.new_own_vel_x   = ctx_reg[3].vax;
        o_next.new_own_vel_y   = ctx_reg[3].vay;
        o_next.new_other_vel_x = ctx_reg[3].vbx;
        o_next.new_other_vel_y = ctx_reg[3].vby;
        unique case (ctx_reg[3].mode)
            cvr_pkg::OUT_WALL:
            begin
                o_next.new_own_vel_x = cvr_pkg::sat32(s_ax[cvr_pkg::SAT_W-1:0]);
                o_next.new_own_vel_y = cvr_pkg::sat32(s_ay[cvr_pkg::SAT_W-1:0]);
            end
            cvr_pkg::OUT_PAIR:
            begin
                o_next.new_own_vel_x   = cvr_pkg::sat32(s_ax[cvr_pkg::SAT_W-1:0]);
                o_next.new_own_vel_y   = cvr_pkg::sat32(s_ay[cvr_pkg::SAT_W-1:0]);
                o_next.new_other_vel_x = cvr_pkg::sat32(s_bx[cvr_pkg::SAT_W-1:0]);
                o_next.new_other_vel_y = cvr_pkg::sat32(s_by[cvr_pkg::SAT_W-1:0]);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[0] <= in_ctx;
            for (int k = 1; k < 4; k++)
                ctx_reg[k] <= ctx_reg[k-1];
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
            b4_reg <= b4_next;
            o_reg  <= o_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_vld};
    end

    assign out_vld  = vld_reg[4];
    assign out_data = o_reg;

endmodule

`default_nettype wire
